// ===== rtl/core/htb_pkg.sv =====
// Shared constants and types of the Huffman tree builder.
package htb_pkg;

	localparam int DEFAULT_MAX_LEAVES = 32;
	localparam int W_WIDTH            = 16;
	localparam int SYM_WIDTH          = 16;
	localparam int NW_WIDTH           = 21;
	localparam int DEPTH_WIDTH        = 6;
	// Tree depth is carried modulo 32 on its way down the walk.
	localparam int DEPTH_BITS         = 5;

	typedef enum logic [3:0] {
		S_IDLE,
		S_SCAN,
		S_PLACE,
		S_SHIFT,
		S_PUT,
		S_BUILD,
		S_INIT,
		S_FIND0,
		S_FIND,
		S_MERGE,
		S_PACK,
		S_APPEND,
		S_ROOT,
		S_ROOTD,
		S_EMIT,
		S_POP
	} state_t;

endpackage

// ===== rtl/core/htb_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
module htb_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== rtl/core/huffman_tree_builder_core.sv =====
// Huffman tree builder: sorted probe store, tree construction and preorder output.
//
// Input words (weight, symbol, last_probe) are taken on in_valid while in_stall
// is low. Each word is inserted into a list of leaves sorted by weight and then
// by signed symbol; an exact duplicate is dropped, and a new word that finds the
// list full is dropped and sets the dropped flag of the batch. Insertion scans
// the node memory one entry per cycle and shifts the tail one entry per cycle.
// The word marked last_probe then starts the build: the leaves are copied into
// the work list, and every merge makes one pass to find the two lightest
// entries and one pass to compact the list. The walk then emits the tree in
// preorder, one output word per cycle for an internal node while out_stall
// lets the output register load; a leaf that resumes from the stack first
// passes through S_POP. The work list memory doubles as the walk stack.
// One output register parts the result side from the engine: a stall on
// out_stall holds that word and pauses the walk, and new input words are not
// taken until the last word of the batch is in the output register. Reset
// empties the list and clears the dropped flag; memory contents are not
// cleared and need no clearing pass.
module huffman_tree_builder_core #(
	parameter int MAX_LEAVES = htb_pkg::DEFAULT_MAX_LEAVES
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	output logic                                  in_stall,
	input  logic [htb_pkg::W_WIDTH-1:0]           weight,
	input  logic signed [htb_pkg::SYM_WIDTH-1:0]  symbol,
	input  logic                                  last_probe,
	output logic                                  out_valid,
	input  logic                                  out_stall,
	output logic [htb_pkg::DEPTH_WIDTH-1:0]       depth,
	output logic [htb_pkg::NW_WIDTH-1:0]          node_weight,
	output logic signed [htb_pkg::SYM_WIDTH-1:0]  node_symbol,
	output logic                                  dropped,
	output logic                                  last_node
);

	import htb_pkg::*;

	localparam int NODES = 2 * MAX_LEAVES - 1;
	localparam int NIW   = $clog2(NODES);
	localparam int LIW   = $clog2(MAX_LEAVES);
	localparam int CW    = $clog2(MAX_LEAVES + 1);
	localparam int NWORD = NW_WIDTH + SYM_WIDTH + 2 * NIW;
	localparam int LWORD = NIW + NW_WIDTH;

	typedef struct packed {
		logic [NW_WIDTH-1:0]         wt;
		logic signed [SYM_WIDTH-1:0] sym;
		logic [NIW-1:0]              left;
		logic [NIW-1:0]              right;
	} node_word_t;

	// Work list entry; on the walk stack the weight field carries the depth.
	typedef struct packed {
		logic [NIW-1:0]      idx;
		logic [NW_WIDTH-1:0] wt;
	} list_word_t;

	state_t state_q, state_d;

	logic [W_WIDTH-1:0]         w_q;
	logic signed [SYM_WIDTH-1:0] s_q;
	logic                       last_q;
	logic [CW-1:0]              len_q, idx_q, pos_q, leaves_q, wlen_q;
	logic [CW-1:0]              a_q, b_q, wp_q, sp_q;
	logic [NIW-1:0]             next_q, cur_q, na_q, nb_q;
	logic [NW_WIDTH-1:0]        wa_q, wb_q;
	logic                       hb_q, ovf_q;
	logic [DEPTH_BITS-1:0]      dep_q;

	logic                       out_v_q, lastn_q, drop_q;
	logic [DEPTH_WIDTH-1:0]     depth_q;
	logic [NW_WIDTH-1:0]        nw_q;
	logic signed [SYM_WIDTH-1:0] ns_q;

	logic                       node_we;
	logic [NIW-1:0]             node_waddr, node_raddr;
	node_word_t                 node_wdata, nrd;
	logic [NWORD-1:0]           node_rdata;
	logic                       list_we;
	logic [LIW-1:0]             list_waddr, list_raddr;
	list_word_t                 list_wdata, lrd;
	logic [LWORD-1:0]           list_rdata;

	logic                       ent_eq, ent_gt, full, out_free, internal;
	logic                       take_a, take_b, keep, out_load;
	logic [CW-1:0]              idx_inc;
	logic [NW_WIDTH-1:0]        w_ext, sum;

	htb_ram #(.WIDTH(NWORD), .DEPTH(NODES)) u_node_ram (
		.clk   (clk),
		.we    (node_we),
		.waddr (node_waddr),
		.wdata (node_wdata),
		.raddr (node_raddr),
		.rdata (node_rdata)
	);

	htb_ram #(.WIDTH(LWORD), .DEPTH(MAX_LEAVES)) u_list_ram (
		.clk   (clk),
		.we    (list_we),
		.waddr (list_waddr),
		.wdata (list_wdata),
		.raddr (list_raddr),
		.rdata (list_rdata)
	);

	assign nrd      = node_rdata;
	assign lrd      = list_rdata;
	assign w_ext    = NW_WIDTH'(w_q);
	assign ent_eq   = (nrd.wt == w_ext) && (nrd.sym == s_q);
	assign ent_gt   = (nrd.wt > w_ext) || ((nrd.wt == w_ext) && (nrd.sym > s_q));
	assign full     = len_q >= CW'(MAX_LEAVES);
	assign out_free = !out_v_q || !out_stall;
	assign internal = cur_q >= NIW'(leaves_q);
	assign idx_inc  = idx_q + CW'(1);
	assign sum      = wa_q + wb_q;
	// A tie keeps the earlier list position, so only strictly lighter entries move.
	assign take_a   = (idx_q == '0) || (lrd.wt < wa_q);
	assign take_b   = !take_a && (!hb_q || (lrd.wt < wb_q));
	assign keep     = (idx_q != a_q) && (idx_q != b_q);
	assign out_load = (state_q == S_EMIT) && out_free;
	assign in_stall = state_q != S_IDLE;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		node_we    = 1'b0;
		node_waddr = '0;
		node_wdata = '0;
		node_raddr = '0;
		list_we    = 1'b0;
		list_waddr = '0;
		list_wdata = '0;
		list_raddr = '0;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					state_d = (len_q == '0) ? S_PLACE : S_SCAN;
				end
			end
			S_SCAN: begin
				node_raddr = NIW'(idx_inc);
				if (ent_eq) begin
					state_d = last_q ? S_BUILD : S_IDLE;
				end else if (ent_gt || (idx_q == len_q - CW'(1))) begin
					state_d = S_PLACE;
				end
			end
			S_PLACE: begin
				node_raddr = NIW'(len_q - CW'(1));
				if (full) begin
					state_d = last_q ? S_BUILD : S_IDLE;
				end else if (pos_q == len_q) begin
					state_d = S_PUT;
				end else begin
					state_d = S_SHIFT;
				end
			end
			S_SHIFT: begin
				node_we    = 1'b1;
				node_waddr = NIW'(idx_inc);
				node_wdata = nrd;
				node_raddr = (idx_q == '0) ? '0 : NIW'(idx_q - CW'(1));
				if (idx_q == pos_q) begin
					state_d = S_PUT;
				end
			end
			S_PUT: begin
				node_we        = 1'b1;
				node_waddr     = NIW'(pos_q);
				node_wdata.wt  = w_ext;
				node_wdata.sym = s_q;
				state_d        = last_q ? S_BUILD : S_IDLE;
			end
			S_BUILD: begin
				state_d = S_INIT;
			end
			S_INIT: begin
				list_we        = 1'b1;
				list_waddr     = LIW'(idx_q);
				list_wdata.idx = NIW'(idx_q);
				list_wdata.wt  = nrd.wt;
				node_raddr     = NIW'(idx_inc);
				if (idx_q == leaves_q - CW'(1)) begin
					state_d = (leaves_q == CW'(1)) ? S_ROOT : S_FIND0;
				end
			end
			S_FIND0: begin
				state_d = S_FIND;
			end
			S_FIND: begin
				list_raddr = (idx_inc < wlen_q) ? LIW'(idx_inc) : '0;
				if (idx_q == wlen_q - CW'(1)) begin
					state_d = S_MERGE;
				end
			end
			S_MERGE: begin
				node_we          = 1'b1;
				node_waddr       = next_q;
				node_wdata.wt    = sum;
				node_wdata.left  = na_q;
				node_wdata.right = nb_q;
				state_d          = S_PACK;
			end
			S_PACK: begin
				list_raddr = (idx_inc < wlen_q) ? LIW'(idx_inc) : '0;
				list_we    = keep;
				list_waddr = LIW'(wp_q);
				list_wdata = lrd;
				if (idx_q == wlen_q - CW'(1)) begin
					state_d = S_APPEND;
				end
			end
			S_APPEND: begin
				list_we        = 1'b1;
				list_waddr     = LIW'(wlen_q - CW'(2));
				list_wdata.idx = next_q;
				list_wdata.wt  = sum;
				state_d        = (wlen_q == CW'(2)) ? S_ROOT : S_FIND0;
			end
			S_ROOT: begin
				state_d = S_ROOTD;
			end
			S_ROOTD: begin
				node_raddr = lrd.idx;
				state_d    = S_EMIT;
			end
			S_EMIT: begin
				node_raddr = cur_q;
				if (out_free) begin
					if (internal) begin
						// Right child waits on the stack, the left one is visited next.
						list_we        = 1'b1;
						list_waddr     = LIW'(sp_q);
						list_wdata.idx = nrd.right;
						list_wdata.wt  = NW_WIDTH'(DEPTH_BITS'(dep_q + 1'b1));
						node_raddr     = nrd.left;
					end else if (sp_q == '0) begin
						state_d = S_IDLE;
					end else begin
						list_raddr = LIW'(sp_q - CW'(1));
						state_d    = S_POP;
					end
				end
			end
			S_POP: begin
				node_raddr = lrd.idx;
				state_d    = S_EMIT;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q <= '0;
			ovf_q <= 1'b0;
		end else begin
			if (state_q == S_PUT) begin
				len_q <= len_q + CW'(1);
			end else if (out_load && !internal && (sp_q == '0)) begin
				len_q <= '0;
			end
			if ((state_q == S_PLACE) && full) begin
				ovf_q <= 1'b1;
			end else if (out_load && !internal && (sp_q == '0)) begin
				ovf_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				w_q    <= weight;
				s_q    <= symbol;
				last_q <= last_probe;
				idx_q  <= '0;
				pos_q  <= '0;
			end
			S_SCAN: begin
				idx_q <= idx_inc;
				pos_q <= ent_gt ? idx_q : len_q;
			end
			S_PLACE: begin
				idx_q <= len_q - CW'(1);
			end
			S_SHIFT: begin
				idx_q <= idx_q - CW'(1);
			end
			S_BUILD: begin
				idx_q    <= '0;
				leaves_q <= len_q;
			end
			S_INIT: begin
				idx_q  <= idx_inc;
				wlen_q <= leaves_q;
				next_q <= NIW'(leaves_q);
			end
			S_FIND0: begin
				idx_q <= '0;
				hb_q  <= 1'b0;
			end
			S_FIND: begin
				idx_q <= idx_inc;
				if (take_a) begin
					b_q  <= a_q;
					wb_q <= wa_q;
					nb_q <= na_q;
					hb_q <= hb_q || (idx_q != '0);
					a_q  <= idx_q;
					wa_q <= lrd.wt;
					na_q <= lrd.idx;
				end else if (take_b) begin
					b_q  <= idx_q;
					wb_q <= lrd.wt;
					nb_q <= lrd.idx;
					hb_q <= 1'b1;
				end
			end
			S_MERGE: begin
				idx_q <= '0;
				wp_q  <= '0;
			end
			S_PACK: begin
				idx_q <= idx_inc;
				if (keep) begin
					wp_q <= wp_q + CW'(1);
				end
			end
			S_APPEND: begin
				wlen_q <= wlen_q - CW'(1);
				next_q <= next_q + NIW'(1);
			end
			S_ROOTD: begin
				cur_q <= lrd.idx;
				dep_q <= DEPTH_BITS'(1);
				sp_q  <= '0;
			end
			S_EMIT: begin
				if (out_free) begin
					if (internal) begin
						cur_q <= nrd.left;
						dep_q <= dep_q + 1'b1;
						sp_q  <= sp_q + CW'(1);
					end else if (sp_q != '0) begin
						sp_q <= sp_q - CW'(1);
					end
				end
			end
			S_POP: begin
				cur_q <= lrd.idx;
				dep_q <= lrd.wt[DEPTH_BITS-1:0];
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (out_load) begin
			out_v_q <= 1'b1;
		end else if (!out_stall) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			depth_q <= DEPTH_WIDTH'(dep_q);
			nw_q    <= nrd.wt;
			ns_q    <= nrd.sym;
			drop_q  <= ovf_q;
			lastn_q <= !internal && (sp_q == '0);
		end
	end

	assign out_valid   = out_v_q;
	assign depth       = depth_q;
	assign node_weight = nw_q;
	assign node_symbol = ns_q;
	assign dropped     = drop_q;
	assign last_node   = lastn_q;

	a_len_cap: assert property (@(posedge clk) disable iff (!arst_n)
		len_q <= CW'(MAX_LEAVES))
		else $error("leaf count exceeds capacity");

	a_find_len: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_FIND) |-> (wlen_q >= CW'(2)))
		else $error("merge search started on a list of fewer than two entries");

	a_pack_order: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_PACK) |-> (wp_q <= idx_q))
		else $error("compaction write overtook its read");

	a_batch_end: assert property (@(posedge clk) disable iff (!arst_n)
		(out_load && !internal && (sp_q == '0)) |=>
		(state_q == S_IDLE && len_q == '0 && !ovf_q && out_valid && last_node))
		else $error("batch did not close after its final word");

	a_stack_cap: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_EMIT) |-> (sp_q < CW'(MAX_LEAVES)))
		else $error("walk stack overflow");

endmodule

// ===== sim/huffman_tree_builder_core_tb.sv =====
// Testbench of the Huffman tree builder: random and directed probe batches checked against a predictor.
module huffman_tree_builder_core_tb;
	import htb_pkg::*;

	localparam int LEAF_CAP   = 32;
	localparam int NODE_SLOTS = 63;
	localparam int STALL_LIMIT = 40000;

	typedef struct packed {
		logic [DEPTH_WIDTH-1:0] depth;
		logic [NW_WIDTH-1:0]    weight;
		logic [SYM_WIDTH-1:0]   symbol;
		logic                   dropped;
		logic                   last;
	} tree_node_t;

	logic                        clk = 1'b0;
	logic                        arst_n;
	logic                        in_valid;
	logic                        in_stall;
	logic [W_WIDTH-1:0]          weight;
	logic signed [SYM_WIDTH-1:0] symbol;
	logic                        last_probe;
	logic                        out_valid;
	logic                        out_stall;
	logic [DEPTH_WIDTH-1:0]      depth;
	logic [NW_WIDTH-1:0]         node_weight;
	logic signed [SYM_WIDTH-1:0] node_symbol;
	logic                        dropped;
	logic                        last_node;

	huffman_tree_builder_core i_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.weight(weight), .symbol(symbol), .last_probe(last_probe),
		.out_valid(out_valid), .out_stall(out_stall),
		.depth(depth), .node_weight(node_weight), .node_symbol(node_symbol),
		.dropped(dropped), .last_node(last_node)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Predictor state: the sorted leaf list of the batch being loaded.
	logic [W_WIDTH-1:0]          leaf_w [LEAF_CAP];
	logic signed [SYM_WIDTH-1:0] leaf_s [LEAF_CAP];
	int                          leaf_count;
	bit                          batch_dropped;

	tree_node_t expected_nodes[$];
	int  errors;
	int  idle_pct;
	int  stall_pct;
	int  hold_left;
	bit  hold_req;
	int  quiet_cycles;
	int  words_sent;

	task automatic insert_leaf(input logic [W_WIDTH-1:0] w, input logic signed [SYM_WIDTH-1:0] s);
		int pos;
		pos = 0;
		while (pos < leaf_count) begin
			if (leaf_w[pos] == w && leaf_s[pos] == s)
				return;
			if (leaf_w[pos] > w || (leaf_w[pos] == w && leaf_s[pos] > s))
				break;
			pos++;
		end
		if (leaf_count >= LEAF_CAP) begin
			batch_dropped = 1'b1;
			return;
		end
		for (int i = leaf_count; i > pos; i--) begin
			leaf_w[i] = leaf_w[i-1];
			leaf_s[i] = leaf_s[i-1];
		end
		leaf_w[pos] = w;
		leaf_s[pos] = s;
		leaf_count++;
	endtask

	// Builds the tree of the loaded batch and queues its nodes in preorder.
	task automatic build_tree_and_walk();
		logic [NW_WIDTH-1:0]  nw [NODE_SLOTS];
		logic [SYM_WIDTH-1:0] ns [NODE_SLOTS];
		int lc [NODE_SLOTS];
		int rc [NODE_SLOTS];
		int wl [LEAF_CAP];
		int stack_nd [$];
		int stack_dp [$];
		int len, next, a, b, na, nb, nd, dp;
		tree_node_t t;
		for (int i = 0; i < leaf_count; i++) begin
			nw[i] = leaf_w[i];
			ns[i] = leaf_s[i];
			wl[i] = i;
		end
		len = leaf_count;
		next = leaf_count;
		while (len > 1 && next < NODE_SLOTS) begin
			a = 0;
			b = 1;
			if (nw[wl[1]] < nw[wl[0]]) begin
				a = 1;
				b = 0;
			end
			for (int j = 2; j < len; j++) begin
				if (nw[wl[j]] < nw[wl[a]]) begin
					b = a;
					a = j;
				end else if (nw[wl[j]] < nw[wl[b]]) begin
					b = j;
				end
			end
			na = wl[a];
			nb = wl[b];
			nw[next] = nw[na] + nw[nb];
			ns[next] = '0;
			lc[next] = na;
			rc[next] = nb;
			// Remove the higher position first so the lower one stays valid.
			for (int k = (a > b ? a : b); k + 1 < len; k++)
				wl[k] = wl[k+1];
			len--;
			for (int k = (a > b ? b : a); k + 1 < len; k++)
				wl[k] = wl[k+1];
			len--;
			wl[len & 31] = next;
			len++;
			next++;
		end
		stack_nd = {stack_nd, wl[0]};
		stack_dp = {stack_dp, 1};
		while (stack_nd.size() > 0) begin
			nd = stack_nd.pop_back();
			dp = stack_dp.pop_back();
			if (nd >= leaf_count) begin
				stack_nd = {stack_nd, rc[nd]};
				stack_dp = {stack_dp, (dp + 1) & 31};
				stack_nd = {stack_nd, lc[nd]};
				stack_dp = {stack_dp, (dp + 1) & 31};
			end
			t.depth   = dp[DEPTH_WIDTH-1:0];
			t.weight  = nw[nd];
			t.symbol  = ns[nd];
			t.dropped = batch_dropped;
			t.last    = (stack_nd.size() == 0);
			expected_nodes = {expected_nodes, t};
		end
		leaf_count = 0;
		batch_dropped = 1'b0;
	endtask

	// Offers one word, waits for its acceptance and updates the predictor.
	// Valid stays high on return so that a following word can go out back to back.
	task automatic send_word(input logic [W_WIDTH-1:0] w, input logic signed [SYM_WIDTH-1:0] s,
			input logic lst);
		if ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < idle_pct);
		end
		in_valid   <= 1'b1;
		weight     <= w;
		symbol     <= s;
		last_probe <= lst;
		do @(posedge clk); while (in_stall);
		insert_leaf(w, s);
		if (lst)
			build_tree_and_walk();
		words_sent++;
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		while (expected_nodes.size() > 0)
			@(posedge clk);
		repeat (60) @(posedge clk);
	endtask

	task automatic send_random_batch(input int size);
		int wmax, smode;
		wmax = $urandom_range(3) == 0 ? 65535 : ($urandom_range(1) ? 7 : 300);
		smode = $urandom_range(2);
		for (int i = 0; i < size; i++)
			send_word($urandom_range(wmax),
				smode == 0 ? 16'($urandom) : 16'($urandom_range(5)) - 16'sd2,
				i == size - 1);
	endtask

	task automatic test_directed();
		// Single-probe batches at the extremes: each is one leaf at depth 1.
		send_word(16'd0, -16'sd32768, 1'b1);
		send_word(16'hFFFF, 16'sd32767, 1'b1);
		// Ties, a duplicate, and extreme fields inside one batch.
		send_word(16'd5, 16'sd3, 1'b0);
		send_word(16'd5, 16'sd3, 1'b0);
		send_word(16'd5, -16'sd1, 1'b0);
		send_word(16'd5, 16'sd7, 1'b0);
		send_word(16'hFFFF, 16'sd32767, 1'b0);
		send_word(16'hFFFF, -16'sd32768, 1'b0);
		send_word(16'd0, 16'sd0, 1'b1);
		// Equal weights throughout.
		for (int i = 0; i < 4; i++)
			send_word(16'd9, 16'(i), i == 3);
		// One probe, then the last probe as a duplicate of it.
		send_word(16'd1, 16'sd1, 1'b0);
		send_word(16'd1, 16'sd1, 1'b1);
		wait_drained();
	endtask

	task automatic test_deep_tree();
		int f0, f1, f2;
		f0 = 1;
		f1 = 1;
		for (int i = 0; i < 23; i++) begin
			send_word(16'(f0), 16'(i), i == 22);
			f2 = f0 + f1;
			f0 = f1;
			f1 = f2;
		end
		wait_drained();
	endtask

	task automatic test_overflow();
		for (int i = 0; i < 38; i++)
			send_word(16'($urandom_range(65535)), 16'(i * 1000 - 18000), i == 37);
		wait_drained();
	endtask

	task automatic test_random(input int target, input int ipct, input int spct);
		int start;
		idle_pct = ipct;
		stall_pct = spct;
		start = words_sent;
		while (words_sent - start < target)
			send_random_batch($urandom_range(7) == 0 ? $urandom_range(33, 40) : $urandom_range(1, 12));
		wait_drained();
	endtask

	task automatic test_backpressure();
		idle_pct = 0;
		stall_pct = 0;
		hold_req = 1'b1;
		for (int i = 0; i < 3; i++)
			send_random_batch(6);
		wait_drained();
	endtask

	always @(posedge clk) begin
		if (hold_req) begin
			hold_req = 1'b0;
			hold_left = 600;
		end
		if (hold_left > 0) begin
			hold_left = hold_left - 1;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(99) < stall_pct);
		end
	end

	always @(posedge clk) begin
		tree_node_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_nodes.size() == 0) begin
				$display("%0t: unexpected node d=%0d w=%0d s=%0d", $time, depth, node_weight,
					node_symbol);
				errors++;
			end else begin
				want = expected_nodes.pop_front();
				if (depth !== want.depth || node_weight !== want.weight
						|| node_symbol !== want.symbol || dropped !== want.dropped
						|| last_node !== want.last) begin
					$display("%0t: expected d=%0d w=%0d s=%0d drop=%0b last=%0b, got d=%0d w=%0d s=%0d drop=%0b last=%0b",
						$time, want.depth, want.weight, $signed(want.symbol), want.dropped,
						want.last, depth, node_weight, node_symbol, dropped, last_node);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles > STALL_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	initial begin
		errors = 0;
		words_sent = 0;
		leaf_count = 0;
		batch_dropped = 1'b0;
		idle_pct = 0;
		stall_pct = 0;
		hold_left = 0;
		hold_req = 1'b0;
		quiet_cycles = 0;
		arst_n = 1'b0;
		in_valid <= 1'b0;
		weight <= '0;
		symbol <= '0;
		last_probe <= 1'b0;
		out_stall <= 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_deep_tree();
		test_overflow();
		test_random(90, 0, 0);
		test_random(90, 79, 0);
		test_random(90, 0, 79);
		test_random(90, 9, 9);
		test_backpressure();
		if (errors == 0 && expected_nodes.size() == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

// ===== huffman_tree_builder_core.f =====
rtl/core/htb_pkg.sv
rtl/core/htb_ram.sv
rtl/core/huffman_tree_builder_core.sv
sim/huffman_tree_builder_core_tb.sv
